// ===== src/obla_pkg.sv =====
package obla_pkg;

  // Message kinds.
  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_UPDATE  = 2'd1;
  localparam logic [1:0] REQ_DELETE  = 2'd2;
  localparam logic [1:0] REQ_EXECUTE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam int VOL_W = 48;
  localparam logic [VOL_W-1:0] VOL_TOP = '1;
  localparam logic [3:0] DEPTH_RESET = 4'd5;

  // One price level as stored in the level memory.
  typedef struct packed {
    logic signed [31:0] price;
    logic [VOL_W-1:0]   vol;
  } lvl_t;

  // One symbol slot.
  typedef struct packed {
    logic        vld;
    logic [63:0] name;
  } sym_t;

endpackage

// ===== src/obla_ram.sv =====
module obla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/order_book_level_aggregator.sv =====
// Order book price-level aggregator. Each input word is one order message
// (add, update, delete or execute) for a symbol; the block keeps the resting
// orders, and for every symbol and side a price-sorted list of total volume
// per level, all in single-port-write memories that a small sequencer walks
// one entry at a time. After reset a clearing pass runs with in_stall high;
// configuration writes are taken throughout. A message then scans the
// symbol table and the order table (each memory read goes through the
// registered read port), visits levels in the sorted search, moves levels
// when a level is inserted or removed, and emits its result words, waiting
// on any output stall. The order-table scan dominates. One message is in
// flight at a time: in_stall is low only while the sequencer is idle. Each
// message produces one result word per reported level, bids (highest
// prices) first and then asks, each side listed highest price first, with
// last set on the final word; a symbol with nothing to report gives a
// single word with level_valid low.
module order_book_level_aggregator #(
  parameter int MAX_ORDERS  = 1024,
  parameter int MAX_SYMBOLS = 16,
  parameter int MAX_LEVELS  = 64,
  parameter int MAX_DEPTH   = 8
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration: report depth.
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  // Message channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [63:0]        symbol_name,
  input  logic               side_sell,
  input  logic [31:0]        order_ident,
  input  logic signed [31:0] new_price,
  input  logic [31:0]        qty,
  input  logic [63:0]        seq_id,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_seq,
  output logic [63:0]        out_symbol,
  output logic [1:0]         status,
  output logic               level_valid,
  output logic               level_side,
  output logic [2:0]         level_rank,
  output logic signed [31:0] level_price,
  output logic [47:0]        level_volume,
  output logic               last
);

  localparam int SYM_W  = MAX_SYMBOLS > 1 ? $clog2(MAX_SYMBOLS) : 1;
  localparam int BOOK_W = SYM_W + 1;
  localparam int OA_W   = $clog2(MAX_ORDERS);
  localparam int LVL_AW = $clog2(MAX_LEVELS);
  localparam int CNT_W  = $clog2(MAX_LEVELS + 1);
  localparam int NBOOK  = 2 ** BOOK_W;
  localparam int CLR_N  = MAX_ORDERS > NBOOK ? MAX_ORDERS : NBOOK;
  localparam int CLR_W  = $clog2(CLR_N);
  localparam logic [3:0] LIM = 4'(MAX_DEPTH < 8 ? MAX_DEPTH : 8);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEVELS);

  // Sequencer states.
  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_SYM_RD   = 5'd2;
  localparam logic [4:0] S_SYM_CHK  = 5'd3;
  localparam logic [4:0] S_ORD_RD   = 5'd4;
  localparam logic [4:0] S_ORD_CHK  = 5'd5;
  localparam logic [4:0] S_DISP     = 5'd6;
  localparam logic [4:0] S_CNT_RD   = 5'd7;
  localparam logic [4:0] S_CNT_LD   = 5'd8;
  localparam logic [4:0] S_OP       = 5'd9;
  localparam logic [4:0] S_FIND_RD  = 5'd10;
  localparam logic [4:0] S_FIND_CHK = 5'd11;
  localparam logic [4:0] S_ACT      = 5'd12;
  localparam logic [4:0] S_SHU_RD   = 5'd13;
  localparam logic [4:0] S_SHU_WR   = 5'd14;
  localparam logic [4:0] S_SHD_RD   = 5'd15;
  localparam logic [4:0] S_SHD_WR   = 5'd16;
  localparam logic [4:0] S_ADD_CHK  = 5'd17;
  localparam logic [4:0] S_UPD_C1   = 5'd18;
  localparam logic [4:0] S_UPD_C2   = 5'd19;
  localparam logic [4:0] S_UPD_SUB  = 5'd20;
  localparam logic [4:0] S_UPD_ADD  = 5'd21;
  localparam logic [4:0] S_ORD_WR   = 5'd22;
  localparam logic [4:0] S_RP_START = 5'd23;
  localparam logic [4:0] S_RP_C0    = 5'd24;
  localparam logic [4:0] S_RP_C1    = 5'd25;
  localparam logic [4:0] S_RP_NEXT  = 5'd26;
  localparam logic [4:0] S_RP_DAT   = 5'd27;
  localparam logic [4:0] S_RP_EMPTY = 5'd28;
  localparam logic [4:0] S_RP_WAIT  = 5'd29;

  typedef struct packed {
    logic             vld;
    logic [SYM_W-1:0] slot;
    logic             side;
    logic [31:0]      id;
    logic [31:0]      price;
    logic [31:0]      vol;
  } order_t;

  // Control and message registers.
  logic [4:0]        state;
  logic [4:0]        fret;
  logic [4:0]        aret;
  logic [CLR_W-1:0]  clr_idx;
  logic [3:0]        depth_reg;
  logic [1:0]        r_type;
  logic [63:0]       r_sym;
  logic              r_side;
  logic [31:0]       r_id;
  logic signed [31:0] r_price;
  logic [31:0]       r_qty;
  logic [63:0]       r_seq;
  logic [1:0]        st_reg;

  // Scan results.
  logic [SYM_W-1:0]  sscan;
  logic [SYM_W-1:0]  sidx;
  logic [SYM_W-1:0]  s_free;
  logic              s_hit;
  logic              s_free_ok;
  logic [OA_W-1:0]   oscan;
  logic [OA_W-1:0]   oidx;
  logic [OA_W-1:0]   o_free;
  logic              o_hit;
  logic              o_free_ok;
  logic signed [31:0] o_price;
  logic [31:0]       o_vol;

  // Level operation registers.
  logic [BOOK_W-1:0] book;
  logic [CNT_W-1:0]  cnt;
  logic signed [31:0] target;
  logic [31:0]       v;
  logic              mode_sub;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  j;
  logic              found;
  logic [47:0]       lvol;

  // Report registers.
  logic [CNT_W-1:0]  cnt0;
  logic [CNT_W-1:0]  cnt1;
  logic              rside;
  logic [3:0]        rrank;

  // Memory ports.
  logic                      sym_we;
  logic [SYM_W-1:0]          sym_waddr;
  obla_pkg::sym_t            sym_wdata;
  logic [SYM_W-1:0]          sym_raddr;
  obla_pkg::sym_t            sd;
  logic                      ord_we;
  logic [OA_W-1:0]           ord_waddr;
  order_t                    ord_wdata;
  logic [OA_W-1:0]           ord_raddr;
  order_t                    od;
  logic                      cnt_we;
  logic [BOOK_W-1:0]         cnt_waddr;
  logic [CNT_W-1:0]          cnt_wdata;
  logic [BOOK_W-1:0]         cnt_raddr;
  logic [CNT_W-1:0]          cnt_rdata;
  logic                      lvl_we;
  logic [BOOK_W+LVL_AW-1:0]  lvl_waddr;
  obla_pkg::lvl_t            lvl_wdata;
  logic [BOOK_W+LVL_AW-1:0]  lvl_raddr;
  obla_pkg::lvl_t            ld;

  // Derived values.
  logic [3:0]        depth;
  logic [3:0]        k0;
  logic [3:0]        k1;
  logic [CNT_W-1:0]  j_dec;
  logic [CNT_W-1:0]  j_inc;
  logic [CNT_W-1:0]  idx0;
  logic [LVL_AW-1:0] idx1;
  logic [48:0]       sum;
  logic [47:0]       sat_sum;
  logic [31:0]       exec_vol;
  logic              in_acc;
  logic              out_acc;
  logic              order_match;

  obla_ram #(.WIDTH($bits(obla_pkg::sym_t)), .DEPTH(MAX_SYMBOLS)) u_sym_ram (
    .clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(sym_wdata),
    .raddr(sym_raddr), .rdata(sd)
  );

  obla_ram #(.WIDTH($bits(order_t)), .DEPTH(MAX_ORDERS)) u_ord_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(od)
  );

  obla_ram #(.WIDTH(CNT_W), .DEPTH(NBOOK)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  obla_ram #(.WIDTH($bits(obla_pkg::lvl_t)), .DEPTH(2 ** (BOOK_W + LVL_AW))) u_lvl_ram (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(ld)
  );

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // Depth zero acts as one; anything above the hardware limit is clipped.
  assign depth = (depth_reg == 4'd0) ? 4'd1 : ((depth_reg > LIM) ? LIM : depth_reg);
  assign k0    = (cnt0 < CNT_W'(depth)) ? cnt0[3:0] : depth;
  assign k1    = (cnt1 < CNT_W'(depth)) ? cnt1[3:0] : depth;

  assign j_dec   = j - CNT_W'(1);
  assign j_inc   = j + CNT_W'(1);
  // Bids are stored ascending, so the best bid is the top of the list; the
  // ask report starts at the k-th lowest ask and walks down.
  assign idx0    = cnt0 - CNT_W'(1) - CNT_W'(rrank);
  assign idx1    = LVL_AW'(k1 - 4'd1 - rrank);
  assign sum     = {1'b0, lvol} + 49'(v);
  assign sat_sum = sum[48] ? obla_pkg::VOL_TOP : sum[47:0];
  assign exec_vol = (r_qty >= o_vol) ? 32'd0 : (o_vol - r_qty);
  assign order_match = od.vld && s_hit && (od.slot == sidx) && (od.side == r_side) &&
                       (od.id == r_id);

  // Memory port control.
  always_comb begin
    sym_we    = 1'b0;
    sym_waddr = sidx;
    sym_wdata = '{vld: 1'b1, name: r_sym};
    sym_raddr = sscan;
    ord_we    = 1'b0;
    ord_waddr = oidx;
    ord_wdata = '{vld: 1'b0, slot: sidx, side: r_side, id: r_id,
                  price: o_price, vol: o_vol};
    ord_raddr = oscan;
    cnt_we    = 1'b0;
    cnt_waddr = book;
    cnt_wdata = cnt;
    cnt_raddr = book;
    lvl_we    = 1'b0;
    lvl_waddr = {book, j[LVL_AW-1:0]};
    lvl_wdata = ld;
    lvl_raddr = {book, j[LVL_AW-1:0]};
    case (state)
      S_CLR: begin
        sym_we    = 1'b1;
        sym_waddr = clr_idx[SYM_W-1:0];
        sym_wdata = '0;
        ord_we    = 1'b1;
        ord_waddr = clr_idx[OA_W-1:0];
        ord_wdata = '0;
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx[BOOK_W-1:0];
        cnt_wdata = '0;
      end
      S_ACT: begin
        lvl_waddr = {book, pos[LVL_AW-1:0]};
        if (!mode_sub) begin
          lvl_we    = (v != 32'd0) && found;
          lvl_wdata = '{price: target, vol: sat_sum};
        end else begin
          lvl_we    = found && !(lvol <= 48'(v));
          lvl_wdata = '{price: target, vol: lvol - 48'(v)};
        end
      end
      S_SHU_RD: begin
        lvl_raddr = {book, j_dec[LVL_AW-1:0]};
        if (!(j > pos)) begin
          lvl_we    = 1'b1;
          lvl_waddr = {book, pos[LVL_AW-1:0]};
          lvl_wdata = '{price: target, vol: 48'(v)};
          cnt_we    = 1'b1;
          cnt_wdata = cnt + CNT_W'(1);
        end
      end
      S_SHU_WR: begin
        lvl_we = 1'b1;
      end
      S_SHD_RD: begin
        lvl_raddr = {book, j_inc[LVL_AW-1:0]};
        if (!(j_inc < cnt)) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt - CNT_W'(1);
        end
      end
      S_SHD_WR: begin
        lvl_we = 1'b1;
      end
      S_ADD_CHK: begin
        if (found || (cnt < CNT_MAX)) begin
          sym_we    = 1'b1;
          ord_we    = 1'b1;
          ord_waddr = o_free;
          ord_wdata = '{vld: 1'b1, slot: sidx, side: r_side, id: r_id,
                        price: r_price, vol: r_qty};
        end
      end
      S_ORD_WR: begin
        ord_we = 1'b1;
        case (r_type)
          obla_pkg::REQ_UPDATE: begin
            ord_wdata.vld   = (r_qty != 32'd0);
            ord_wdata.price = r_price;
            ord_wdata.vol   = r_qty;
          end
          obla_pkg::REQ_EXECUTE: begin
            ord_wdata.vld = (exec_vol != 32'd0);
            ord_wdata.vol = exec_vol;
          end
          default: begin
            ord_wdata.vld = 1'b0;
          end
        endcase
      end
      S_RP_START: begin
        cnt_raddr = {sidx, 1'b0};
      end
      S_RP_C0: begin
        cnt_raddr = {sidx, 1'b1};
      end
      S_RP_NEXT: begin
        lvl_raddr = rside ? {sidx, 1'b1, idx1} : {sidx, 1'b0, idx0[LVL_AW-1:0]};
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      depth_reg <= obla_pkg::DEPTH_RESET;
    end else begin
      if (cfg_we) begin
        depth_reg <= cfg_wdata;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + CLR_W'(1);
          if (clr_idx == CLR_W'(CLR_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            r_type    <= req_type;
            r_sym     <= symbol_name;
            r_side    <= side_sell;
            r_id      <= order_ident;
            r_price   <= new_price;
            r_qty     <= qty;
            r_seq     <= seq_id;
            sscan     <= '0;
            s_hit     <= 1'b0;
            s_free_ok <= 1'b0;
            o_hit     <= 1'b0;
            o_free_ok <= 1'b0;
            st_reg    <= obla_pkg::ST_OK;
            state     <= S_SYM_RD;
          end
        end
        S_SYM_RD: begin
          state <= S_SYM_CHK;
        end
        S_SYM_CHK: begin
          if (sd.vld && (sd.name == r_sym)) begin
            s_hit <= 1'b1;
            sidx  <= sscan;
          end
          if (!sd.vld && !s_free_ok) begin
            s_free    <= sscan;
            s_free_ok <= 1'b1;
          end
          if (sscan == SYM_W'(MAX_SYMBOLS - 1)) begin
            oscan <= '0;
            state <= S_ORD_RD;
          end else begin
            sscan <= sscan + SYM_W'(1);
            state <= S_SYM_RD;
          end
        end
        S_ORD_RD: begin
          state <= S_ORD_CHK;
        end
        S_ORD_CHK: begin
          if (order_match) begin
            o_hit   <= 1'b1;
            oidx    <= oscan;
            o_price <= od.price;
            o_vol   <= od.vol;
          end
          if (!od.vld && !o_free_ok) begin
            o_free    <= oscan;
            o_free_ok <= 1'b1;
          end
          if (oscan == OA_W'(MAX_ORDERS - 1)) begin
            state <= S_DISP;
          end else begin
            oscan <= oscan + OA_W'(1);
            state <= S_ORD_RD;
          end
        end
        S_DISP: begin
          if (r_type == obla_pkg::REQ_ADD) begin
            if ((r_qty == 32'd0) || o_hit) begin
              state <= S_RP_START;
            end else if ((!s_hit && !s_free_ok) || !o_free_ok) begin
              st_reg <= obla_pkg::ST_FULL;
              state  <= S_RP_START;
            end else begin
              // A new symbol takes its slot only once the add commits.
              sidx  <= s_hit ? sidx : s_free;
              book  <= {(s_hit ? sidx : s_free), r_side};
              state <= S_CNT_RD;
            end
          end else if (!o_hit) begin
            st_reg <= obla_pkg::ST_UNKNOWN;
            state  <= S_RP_START;
          end else begin
            book  <= {sidx, r_side};
            state <= S_CNT_RD;
          end
        end
        S_CNT_RD: begin
          state <= S_CNT_LD;
        end
        S_CNT_LD: begin
          cnt   <= cnt_rdata;
          state <= S_OP;
        end
        S_OP: begin
          j <= '0;
          case (r_type)
            obla_pkg::REQ_ADD: begin
              target <= r_price;
              fret   <= S_ADD_CHK;
              state  <= S_FIND_RD;
            end
            obla_pkg::REQ_UPDATE: begin
              if (r_price == o_price) begin
                target   <= r_price;
                mode_sub <= !(r_qty >= o_vol);
                v        <= (r_qty >= o_vol) ? (r_qty - o_vol) : (o_vol - r_qty);
                fret     <= S_ACT;
                aret     <= S_ORD_WR;
                state    <= S_FIND_RD;
              end else if (r_qty != 32'd0) begin
                target <= r_price;
                fret   <= S_UPD_C1;
                state  <= S_FIND_RD;
              end else begin
                state <= S_UPD_SUB;
              end
            end
            obla_pkg::REQ_DELETE: begin
              target   <= o_price;
              v        <= o_vol;
              mode_sub <= 1'b1;
              fret     <= S_ACT;
              aret     <= S_ORD_WR;
              state    <= S_FIND_RD;
            end
            default: begin
              target   <= o_price;
              v        <= r_qty;
              mode_sub <= 1'b1;
              fret     <= S_ACT;
              aret     <= S_ORD_WR;
              state    <= S_FIND_RD;
            end
          endcase
        end
        S_FIND_RD: begin
          if (j < cnt) begin
            state <= S_FIND_CHK;
          end else begin
            pos   <= j;
            found <= 1'b0;
            state <= fret;
          end
        end
        S_FIND_CHK: begin
          if (ld.price < target) begin
            j     <= j_inc;
            state <= S_FIND_RD;
          end else begin
            pos   <= j;
            found <= (ld.price == target);
            lvol  <= ld.vol;
            state <= fret;
          end
        end
        S_ACT: begin
          if (!mode_sub) begin
            if ((v == 32'd0) || found || (cnt >= CNT_MAX)) begin
              state <= aret;
            end else begin
              j     <= cnt;
              state <= S_SHU_RD;
            end
          end else begin
            if (found && (lvol <= 48'(v))) begin
              j     <= pos;
              state <= S_SHD_RD;
            end else begin
              state <= aret;
            end
          end
        end
        S_SHU_RD: begin
          if (j > pos) begin
            state <= S_SHU_WR;
          end else begin
            cnt   <= cnt + CNT_W'(1);
            state <= aret;
          end
        end
        S_SHU_WR: begin
          j     <= j_dec;
          state <= S_SHU_RD;
        end
        S_SHD_RD: begin
          if (j_inc < cnt) begin
            state <= S_SHD_WR;
          end else begin
            cnt   <= cnt - CNT_W'(1);
            state <= aret;
          end
        end
        S_SHD_WR: begin
          j     <= j_inc;
          state <= S_SHD_RD;
        end
        S_ADD_CHK: begin
          if (!found && (cnt >= CNT_MAX)) begin
            st_reg <= obla_pkg::ST_FULL;
            state  <= S_RP_START;
          end else begin
            s_hit    <= 1'b1;
            mode_sub <= 1'b0;
            v        <= r_qty;
            aret     <= S_RP_START;
            state    <= S_ACT;
          end
        end
        S_UPD_C1: begin
          // The new price needs a slot: it is only there if the old level
          // empties out.
          if (!found && (cnt >= CNT_MAX)) begin
            target <= o_price;
            j      <= '0;
            fret   <= S_UPD_C2;
            state  <= S_FIND_RD;
          end else begin
            state <= S_UPD_SUB;
          end
        end
        S_UPD_C2: begin
          if (found && (lvol <= 48'(o_vol))) begin
            state <= S_UPD_SUB;
          end else begin
            st_reg <= obla_pkg::ST_FULL;
            state  <= S_RP_START;
          end
        end
        S_UPD_SUB: begin
          target   <= o_price;
          v        <= o_vol;
          mode_sub <= 1'b1;
          j        <= '0;
          fret     <= S_ACT;
          aret     <= S_UPD_ADD;
          state    <= S_FIND_RD;
        end
        S_UPD_ADD: begin
          target   <= r_price;
          v        <= r_qty;
          mode_sub <= 1'b0;
          j        <= '0;
          fret     <= S_ACT;
          aret     <= S_ORD_WR;
          state    <= S_FIND_RD;
        end
        S_ORD_WR: begin
          state <= S_RP_START;
        end
        S_RP_START: begin
          state <= s_hit ? S_RP_C0 : S_RP_EMPTY;
        end
        S_RP_C0: begin
          cnt0  <= cnt_rdata;
          state <= S_RP_C1;
        end
        S_RP_C1: begin
          cnt1  <= cnt_rdata;
          rside <= 1'b0;
          rrank <= 4'd0;
          state <= S_RP_NEXT;
        end
        S_RP_NEXT: begin
          if ((k0 == 4'd0) && (k1 == 4'd0)) begin
            state <= S_RP_EMPTY;
          end else if (!rside && (rrank < k0)) begin
            state <= S_RP_DAT;
          end else if (!rside) begin
            rside <= 1'b1;
            rrank <= 4'd0;
          end else begin
            state <= S_RP_DAT;
          end
        end
        S_RP_DAT: begin
          out_seq      <= r_seq;
          out_symbol   <= r_sym;
          status       <= st_reg;
          level_valid  <= 1'b1;
          level_side   <= rside;
          level_rank   <= rrank[2:0];
          level_price  <= ld.price;
          level_volume <= ld.vol;
          last         <= (rside && (rrank == k1 - 4'd1)) ||
                          (!rside && (rrank == k0 - 4'd1) && (k1 == 4'd0));
          out_valid    <= 1'b1;
          state        <= S_RP_WAIT;
        end
        S_RP_EMPTY: begin
          out_seq      <= r_seq;
          out_symbol   <= r_sym;
          status       <= st_reg;
          level_valid  <= 1'b0;
          level_side   <= 1'b0;
          level_rank   <= 3'd0;
          level_price  <= '0;
          level_volume <= '0;
          last         <= 1'b1;
          out_valid    <= 1'b1;
          state        <= S_RP_WAIT;
        end
        S_RP_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              rrank <= rrank + 4'd1;
              state <= S_RP_NEXT;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result word is only ever presented from the wait state.
  a_out_in_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_RP_WAIT))
    else $error("result word presented outside the wait state");

  // No message is taken while a result word is pending.
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result word is pending");

  // Delivering the final word of a report returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after the last word");

  // Nothing leaves the block during the clearing pass.
  a_quiet_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> (!out_valid && in_stall))
    else $error("activity during the clearing pass");

endmodule
